// File: hdl/wes_pkg.sv
// ----------------------------------------------------------------------------
// wes_pkg
// Shared types and constants of the weighted event selector: payload structs
// of both channels, mode codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package wes_pkg;

    localparam int MODE_W         = 2;
    localparam int SITE_FIELD_W   = 10;
    localparam int SLOT_W         = 5;
    localparam int RATE_W         = 32;
    localparam int CNT_W          = 5;
    localparam int FRAC_W         = 32;
    localparam int TOTAL_W        = 48;
    localparam int THR_W          = 48;
    localparam int SITE_COUNT_W   = 11;

    localparam logic [SITE_COUNT_W-1:0] SITE_COUNT_RST = 11'd1024;

    localparam logic [MODE_W-1:0] MODE_WR_RATE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_COUNT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SELECT   = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [SITE_FIELD_W-1:0] site;
        logic [SLOT_W-1:0]       slot;
        logic [RATE_W-1:0]       rate_value;
        logic [CNT_W-1:0]        neighbour_count;
        logic [FRAC_W-1:0]       random_fraction;
        logic [TOTAL_W-1:0]      total_rate;
    } req_t;

    typedef struct packed {
        logic [SITE_FIELD_W-1:0] chosen_site;
        logic [SLOT_W-1:0]       chosen_slot;
        logic [THR_W-1:0]        threshold;
        logic                    not_found;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_THR_LO,
        ST_THR_HI,
        ST_THR_SUM,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic thr_lo;
        logic thr_hi;
        logic start;
        logic walk_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic no_sites;
        logic walk_end;
        logic out_free;
    } sts_t;

endpackage

// File: hdl/wes_ctrl.sv
// ----------------------------------------------------------------------------
// wes_ctrl
// Sequencer of the event selector: takes request beats, steps the threshold
// multiply, runs the table walk and hands the result to the output register.
// ----------------------------------------------------------------------------
module wes_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic [wes_pkg::MODE_W-1:0] req_mode,
    output logic                      req_stall,
    output wes_pkg::cmd_t             cmd,
    input  wes_pkg::sts_t             sts
);
    import wes_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && (req_mode == MODE_SELECT))
                begin
                    state_next = ST_THR_LO;
                end
            end
            ST_THR_LO:
            begin
                state_next = ST_THR_HI;
            end
            ST_THR_HI:
            begin
                state_next = ST_THR_SUM;
            end
            ST_THR_SUM:
            begin
                state_next = sts.no_sites ? ST_FINISH : ST_WALK;
            end
            ST_WALK:
            begin
                if (sts.walk_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall  = 1'b0;
                cmd.accept = req_valid;
            end
            ST_THR_LO:
            begin
                cmd.thr_lo = 1'b1;
            end
            ST_THR_HI:
            begin
                cmd.thr_hi = 1'b1;
            end
            ST_THR_SUM:
            begin
                cmd.start = 1'b1;
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hdl/wes_datapath.sv
// ----------------------------------------------------------------------------
// wes_datapath
// Rate and neighbour count memories, site count register, threshold
// multiply, running sum walk and the output register.
// ----------------------------------------------------------------------------
module wes_datapath #(
    parameter int MAX_SITES      = 1024,
    parameter int MAX_NEIGHBOURS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wes_pkg::cmd_t                   cmd,
    output wes_pkg::sts_t                   sts,
    input  wes_pkg::req_t                   req_data,
    input  logic                            cfg_wr_en,
    input  logic [wes_pkg::SITE_COUNT_W-1:0] cfg_wr_data,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output wes_pkg::rsp_t                   rsp_data
);
    import wes_pkg::*;

    localparam int DEPTH   = MAX_SITES * MAX_NEIGHBOURS;
    localparam int SITE_W  = $clog2(MAX_SITES);
    localparam int NSITE_W = SITE_W + 1;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SUM_W   = RATE_W + ADDR_W;
    localparam int CMP_W   = (SUM_W > THR_W) ? SUM_W : THR_W;

    logic [RATE_W-1:0] rate_mem_reg [DEPTH];
    logic [CNT_W-1:0]  cnt_mem_reg  [MAX_SITES];
    logic [RATE_W-1:0] rate_rd_reg;
    logic [CNT_W-1:0]  cnt_rd_reg;

    logic              rate_we;
    logic [ADDR_W-1:0] rate_wr_addr;
    logic              cnt_we;
    logic [SITE_W-1:0] cnt_wr_addr;
    logic [CNT_W-1:0]  cnt_wr_data;

    logic [SITE_COUNT_W-1:0] site_count_reg;
    logic [NSITE_W-1:0]      n_sites;
    logic [SITE_W-1:0]       last_site;

    logic [FRAC_W-1:0]  frac_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [63:0]        lo_prod;
    logic [THR_W-1:0]   hi_prod;
    logic [31:0]        prod_lo_reg;
    logic [THR_W-1:0]   prod_hi_reg;
    logic [THR_W-1:0]   thr_reg;

    logic [SITE_W-1:0] site_reg,      site_next;
    logic [CNT_W-1:0]  slot_reg,      slot_next;
    logic [ADDR_W-1:0] base_reg,      base_next;
    logic [ADDR_W-1:0] addr_reg,      addr_next;
    logic [SUM_W-1:0]  sum_reg,       sum_next;
    logic [CNT_W-1:0]  last_slot_reg, last_slot_next;
    logic              hit_reg,       hit_next;
    logic [SITE_W-1:0] res_site_reg,  res_site_next;

    logic [SUM_W-1:0] sum_add;
    logic             cnt_empty;
    logic             hit;
    logic             site_done;
    logic             last;
    logic             walk_end;

    logic out_valid_reg;
    logic out_free;
    rsp_t rsp_reg;

    // table writes
    always_comb
    begin
        rate_we = cmd.accept && (req_data.mode == MODE_WR_RATE)
                  && (32'(req_data.site) < MAX_SITES)
                  && (req_data.slot != '0)
                  && (32'(req_data.slot) <= MAX_NEIGHBOURS);
        rate_wr_addr = ADDR_W'(32'(req_data.site) * MAX_NEIGHBOURS
                               + 32'(req_data.slot) - 32'd1);
        cnt_we = cmd.accept && (req_data.mode == MODE_WR_COUNT)
                 && (32'(req_data.site) < MAX_SITES);
        cnt_wr_addr = SITE_W'(req_data.site);
        cnt_wr_data = (32'(req_data.neighbour_count) > MAX_NEIGHBOURS)
                      ? CNT_W'(MAX_NEIGHBOURS) : req_data.neighbour_count;
    end

    always_ff @(posedge clk)
    begin
        if (rate_we)
        begin
            rate_mem_reg[rate_wr_addr] <= req_data.rate_value;
        end
        rate_rd_reg <= rate_mem_reg[addr_next];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem_reg[cnt_wr_addr] <= cnt_wr_data;
        end
        cnt_rd_reg <= cnt_mem_reg[site_next];
    end

    // site count limit
    always_comb
    begin
        n_sites = (32'(site_count_reg) > MAX_SITES) ? NSITE_W'(MAX_SITES)
                                                    : NSITE_W'(site_count_reg);
        last_site = SITE_W'(n_sites - NSITE_W'(1));
    end

    // threshold partial products
    always_comb
    begin
        lo_prod = 64'(frac_reg) * 64'(total_reg[31:0]);
        hi_prod = THR_W'(frac_reg) * THR_W'(total_reg[TOTAL_W-1:32]);
    end

    // walk step
    always_comb
    begin
        cnt_empty = (cnt_rd_reg == '0);
        sum_add   = sum_reg + SUM_W'(rate_rd_reg);
        hit       = !cnt_empty && (CMP_W'(sum_add) > CMP_W'(thr_reg));
        site_done = cnt_empty || (slot_reg == cnt_rd_reg);
        last      = (site_reg == last_site);
        walk_end  = hit || (site_done && last);

        site_next      = site_reg;
        slot_next      = slot_reg;
        base_next      = base_reg;
        addr_next      = addr_reg;
        sum_next       = sum_reg;
        last_slot_next = last_slot_reg;
        hit_next       = hit_reg;
        res_site_next  = res_site_reg;

        if (cmd.start)
        begin
            site_next      = '0;
            slot_next      = CNT_W'(1);
            base_next      = '0;
            addr_next      = '0;
            sum_next       = '0;
            last_slot_next = '0;
            hit_next       = 1'b0;
            res_site_next  = '0;
        end
        else if (cmd.walk_step)
        begin
            res_site_next = site_reg;
            hit_next      = hit;
            if (!cnt_empty)
            begin
                sum_next       = sum_add;
                last_slot_next = slot_reg;
            end
            if (!walk_end)
            begin
                if (site_done)
                begin
                    site_next = site_reg + SITE_W'(1);
                    slot_next = CNT_W'(1);
                    base_next = base_reg + ADDR_W'(MAX_NEIGHBOURS);
                    addr_next = base_reg + ADDR_W'(MAX_NEIGHBOURS);
                end
                else
                begin
                    slot_next = slot_reg + CNT_W'(1);
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            frac_reg  <= req_data.random_fraction;
            total_reg <= req_data.total_rate;
        end
        if (cmd.thr_lo)
        begin
            prod_lo_reg <= lo_prod[63:32];
        end
        if (cmd.thr_hi)
        begin
            prod_hi_reg <= hi_prod;
        end
        if (cmd.start)
        begin
            thr_reg <= prod_hi_reg + THR_W'(prod_lo_reg);
        end
        site_reg      <= site_next;
        slot_reg      <= slot_next;
        base_reg      <= base_next;
        addr_reg      <= addr_next;
        sum_reg       <= sum_next;
        last_slot_reg <= last_slot_next;
        hit_reg       <= hit_next;
        res_site_reg  <= res_site_next;
        if (cmd.load_out)
        begin
            rsp_reg.chosen_site <= SITE_FIELD_W'(res_site_reg);
            rsp_reg.chosen_slot <= last_slot_reg;
            rsp_reg.threshold   <= thr_reg;
            rsp_reg.not_found   <= !hit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_count_reg <= SITE_COUNT_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                site_count_reg <= cfg_wr_data;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_free     = !out_valid_reg || !rsp_stall;
    assign sts.no_sites = (n_sites == '0);
    assign sts.walk_end = walk_end;
    assign sts.out_free = out_free;
    assign rsp_valid    = out_valid_reg;
    assign rsp_data     = rsp_reg;

endmodule

// File: hdl/weighted_event_selector.sv
// ----------------------------------------------------------------------------
// weighted_event_selector
// Roulette wheel event picker for kinetic Monte Carlo.
//
// Request channel (req_valid / req_stall / req_data) carries three kinds of
// beat: a rate write for one site and neighbour slot, a neighbour count write
// for one site, and a selection. Writes give no response and leave the
// request side open. A selection scales the random fraction by the total
// rate, then walks sites 0..min(site_count, MAX_SITES)-1 and their slots,
// one memory entry per cycle, until the running sum passes the threshold
// or the last site is done. It steps through THR_LO, THR_HI, THR_SUM, W
// walk steps and FINISH before rsp_valid rises, W being one step per visited
// slot and one per site without slots, at most MAX_SITES * MAX_NEIGHBOURS.
// The single read port of the rate memory sets the walk pace. Only one
// selection is in flight; req_stall is high from THR_LO until IDLE again.
// The response channel (rsp_valid / rsp_stall / rsp_data) has its own output
// register: writes are still taken while a response waits, and a following
// selection holds in its last step until the register is free.
// Reset sets site_count to 1024 and empties the output register; the rate and
// count memories are not cleared and must be written before use.
// ----------------------------------------------------------------------------
module weighted_event_selector #(
    parameter int MAX_SITES      = 1024,
    parameter int MAX_NEIGHBOURS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  wes_pkg::req_t                   req_data,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output wes_pkg::rsp_t                   rsp_data,
    input  logic                            cfg_wr_en,
    input  logic [wes_pkg::SITE_COUNT_W-1:0] cfg_wr_data
);
    import wes_pkg::*;

    cmd_t cmd;
    sts_t sts;

    wes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_mode  (req_data.mode),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    wes_datapath #(
        .MAX_SITES      (MAX_SITES),
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_data    (req_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data)
    );

`ifndef SYNTHESIS
    // a selection beat blocks the request side on the next cycle
    a_select_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (req_data.mode == MODE_SELECT)) |=> req_stall)
        else $error("request side open right after a selection beat");

    // a write beat leaves the request side open
    a_write_open: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (req_data.mode != MODE_SELECT)) |=> !req_stall)
        else $error("request side stalled after a write beat");

    // the output register is loaded only when it can take a beat
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("output register overwritten");

    // a loaded response is presented on the next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> rsp_valid)
        else $error("response not presented after load");
`endif

endmodule

// File: test/weighted_event_selector_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_event_selector_chk
// Watches the request, response and site_count ports of the event selector.
// Mirrors the rate and neighbour count tables from the write beats, works out
// the expected pick for every accepted selection and compares each response
// beat, field by field, with the oldest pick still due.
// ----------------------------------------------------------------------------
module weighted_event_selector_chk (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    input  logic                             req_stall,
    input  wes_pkg::req_t                    req_data,
    input  logic                             rsp_valid,
    input  logic                             rsp_stall,
    input  wes_pkg::rsp_t                    rsp_data,
    input  logic                             cfg_wr_en,
    input  logic [wes_pkg::SITE_COUNT_W-1:0] cfg_wr_data,
    output int                               fail_count,
    output int                               picks_pending
);
    import wes_pkg::*;

    localparam int SITES = 1024;
    localparam int SLOTS = 16;

    logic [RATE_W-1:0]       rate_mirror [SITES*SLOTS];
    logic [CNT_W-1:0]        count_mirror [SITES];
    logic [SITE_COUNT_W-1:0] scan_sites;
    rsp_t                    picks_due [$];
    int                      mismatches;

    initial
    begin
        foreach (rate_mirror[k])
            rate_mirror[k] = '0;
        foreach (count_mirror[k])
            count_mirror[k] = '0;
        mismatches = 0;
    end

    task automatic flag_error(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // roulette walk over the mirrored tables
    function automatic rsp_t pick_event(input logic [FRAC_W-1:0] frac,
                                        input logic [TOTAL_W-1:0] total);
        logic [79:0]      prod;
        logic [THR_W-1:0] bar;
        logic [THR_W-1:0] run;
        int               last;
        int               n;
        bit               hit;
        rsp_t             res;
        prod = {48'd0, frac} * {32'd0, total};
        bar  = prod[79:32];
        last = (scan_sites > SITES) ? SITES : int'(scan_sites);
        res  = '0;
        run  = '0;
        hit  = 1'b0;
        for (int i = 0; i < last && !hit; i++)
        begin
            n = int'(count_mirror[i]);
            for (int s = 1; s <= n && !hit; s++)
            begin
                res.chosen_slot = SLOT_W'(s);
                run = run + THR_W'(rate_mirror[i*SLOTS + s - 1]);
                hit = (run > bar);
            end
            res.chosen_site = SITE_FIELD_W'(i);
        end
        res.threshold = bar;
        res.not_found = !hit;
        return res;
    endfunction

    task automatic take_request(input req_t b);
        case (b.mode)
            MODE_WR_RATE:
                if (b.slot >= 1 && b.slot <= SLOTS)
                    rate_mirror[int'(b.site)*SLOTS + int'(b.slot) - 1] = b.rate_value;
            MODE_WR_COUNT:
                count_mirror[b.site] = (b.neighbour_count > SLOTS) ?
                                       CNT_W'(SLOTS) : b.neighbour_count;
            MODE_SELECT:
                picks_due.push_back(pick_event(b.random_fraction, b.total_rate));
            default:
                ;
        endcase
    endtask

    task automatic match_pick(input rsp_t got);
        rsp_t want;
        if (picks_due.size() == 0)
        begin
            flag_error($sformatf("response site %0d slot %0d with no selection waiting",
                                 got.chosen_site, got.chosen_slot));
            return;
        end
        want = picks_due.pop_front();
        if (got.chosen_site !== want.chosen_site)
            flag_error($sformatf("chosen_site %0d, expected %0d",
                                 got.chosen_site, want.chosen_site));
        if (got.chosen_slot !== want.chosen_slot)
            flag_error($sformatf("chosen_slot %0d, expected %0d",
                                 got.chosen_slot, want.chosen_slot));
        if (got.threshold !== want.threshold)
            flag_error($sformatf("threshold %h, expected %h",
                                 got.threshold, want.threshold));
        if (got.not_found !== want.not_found)
            flag_error($sformatf("not_found %b, expected %b",
                                 got.not_found, want.not_found));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_sites = SITE_COUNT_RST;
            picks_due.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                match_pick(rsp_data);
            if (req_valid && !req_stall)
                take_request(req_data);
            if (cfg_wr_en)
                scan_sites = cfg_wr_data;
        end
        fail_count    <= mismatches;
        picks_pending <= picks_due.size();
    end

endmodule

// File: test/weighted_event_selector_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_event_selector_tb
// Drives rate writes, neighbour count writes, unused-mode beats and
// selections into the event selector, with random gaps and response stalls,
// a long response hold-off and several site_count settings. Every slot a
// count opens is given a rate first, and a selection whose scan reaches a
// site with no count written gets the total of the written leading sites,
// so its walk stops before that site. Checking is done by
// weighted_event_selector_chk.
// ----------------------------------------------------------------------------
module weighted_event_selector_tb;
    import wes_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int SITES       = 1024;
    localparam int SLOTS       = 16;
    localparam int FIRST_SITES = 8;
    localparam int LONG_HOLD   = 2000;
    localparam int SETTLE      = 16;
    localparam int PHASES      = 7;
    localparam int PER_PHASE   = 6;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    req_valid   = 1'b0;
    logic                    req_stall;
    req_t                    req_data    = '0;
    logic                    rsp_valid;
    logic                    rsp_stall   = 1'b0;
    rsp_t                    rsp_data;
    logic                    cfg_wr_en   = 1'b0;
    logic [SITE_COUNT_W-1:0] cfg_wr_data = '0;
    int                      fail_count;
    int                      picks_pending;

    logic [RATE_W-1:0] rate_shadow [SITES*SLOTS];
    bit                rate_set [SITES*SLOTS];
    int                count_shadow [SITES];
    bit                count_set [SITES];
    int                scan_limit = SITES;
    bit                burst      = 1'b0;
    bit                hold_req   = 1'b0;

    weighted_event_selector dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    weighted_event_selector_chk chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_data      (req_data),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp_data      (rsp_data),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .fail_count    (fail_count),
        .picks_pending (picks_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("weighted_event_selector_tb NOT OK");
        $finish;
    end

    function automatic int idle_len();
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic req_t noise_beat();
        req_t b;
        b.mode            = MODE_W'($urandom());
        b.site            = SITE_FIELD_W'($urandom());
        b.slot            = SLOT_W'($urandom());
        b.rate_value      = $urandom();
        b.neighbour_count = CNT_W'($urandom());
        b.random_fraction = $urandom();
        b.total_rate      = {16'($urandom()), 32'($urandom())};
        return b;
    endfunction

    function automatic logic [RATE_W-1:0] draw_rate();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom();
            default: return RATE_W'($urandom_range(1, 32'h0003_ffff));
        endcase
    endfunction

    // leading sites with a written count, up to the current site_count
    function automatic int covered();
        int n;
        n = 0;
        while (n < scan_limit && count_set[n])
            n++;
        return n;
    endfunction

    // sum of every rate in the covered leading sites
    function automatic logic [TOTAL_W-1:0] wheel_total();
        logic [TOTAL_W-1:0] acc;
        int                 last;
        acc  = '0;
        last = covered();
        for (int i = 0; i < last; i++)
            for (int s = 0; s < count_shadow[i]; s++)
                acc = acc + TOTAL_W'(rate_shadow[i*SLOTS + s]);
        return acc;
    endfunction

    task automatic send_beat(input req_t b);
        int gap;
        gap = idle_len();
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            req_data  <= noise_beat();
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= b;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic put_rate(input int site, input int slot, input logic [RATE_W-1:0] v);
        req_t b;
        b            = noise_beat();
        b.mode       = MODE_WR_RATE;
        b.site       = SITE_FIELD_W'(site);
        b.slot       = SLOT_W'(slot);
        b.rate_value = v;
        send_beat(b);
        if (slot >= 1 && slot <= SLOTS)
        begin
            rate_shadow[site*SLOTS + slot - 1] = v;
            rate_set[site*SLOTS + slot - 1]    = 1'b1;
        end
    endtask

    task automatic put_count(input int site, input int cnt);
        req_t b;
        int   used;
        used = (cnt > SLOTS) ? SLOTS : cnt;
        // every slot the count opens needs a rate first
        for (int s = 1; s <= used; s++)
            if (!rate_set[site*SLOTS + s - 1])
                put_rate(site, s, draw_rate());
        b                 = noise_beat();
        b.mode            = MODE_WR_COUNT;
        b.site            = SITE_FIELD_W'(site);
        b.neighbour_count = CNT_W'(cnt);
        send_beat(b);
        count_shadow[site] = used;
        count_set[site]    = 1'b1;
    endtask

    task automatic ask_select(input logic [FRAC_W-1:0] frac,
                              input logic [TOTAL_W-1:0] total);
        req_t b;
        b                 = noise_beat();
        b.mode            = MODE_SELECT;
        b.random_fraction = frac;
        b.total_rate      = total;
        send_beat(b);
    endtask

    task automatic send_spare();
        req_t b;
        b      = noise_beat();
        b.mode = MODE_SPARE;
        send_beat(b);
    endtask

    task automatic random_select();
        logic [FRAC_W-1:0]  frac;
        logic [TOTAL_W-1:0] full;
        logic [TOTAL_W-1:0] total;
        int                 pick;
        bit                 open_end;
        open_end = (covered() < scan_limit);
        full     = wheel_total();
        if (open_end && full == '0)
        begin
            // the walk has to stop inside the covered sites
            put_rate(0, 1, 32'd1);
            if (count_shadow[0] == 0)
                put_count(0, 1);
            full = wheel_total();
        end
        pick = $urandom_range(0, 99);
        frac = $urandom();
        if ($urandom_range(0, 15) == 0)
            frac = '0;
        else if ($urandom_range(0, 15) == 0)
            frac = '1;
        if (open_end || pick < 55)
            total = full;
        else if (pick < 65)
            total = full + TOTAL_W'($urandom_range(0, 32'hffff));
        else if (pick < 72)
            total = '0;
        else if (pick < 80)
            total = '1;
        else
            total = {16'($urandom()), 32'($urandom())};
        ask_select(frac, total);
    endtask

    task automatic random_item(output bit counted);
        int r;
        int site;
        int cnt_pick;
        r        = $urandom_range(0, 99);
        site     = ($urandom_range(0, 4) == 0) ? $urandom_range(0, SITES-1) :
                                                  $urandom_range(0, 31);
        cnt_pick = $urandom_range(0, 9);
        counted  = 1'b1;
        if (r < 40)
            random_select();
        else if (r < 65)
            put_rate(site, $urandom_range(1, SLOTS), draw_rate());
        else if (r < 85)
            put_count(site, (cnt_pick == 0) ? $urandom_range(SLOTS+1, 31) :
                            (cnt_pick == 1) ? $urandom_range(0, SLOTS) :
                                              $urandom_range(0, 4));
        else
        begin
            counted = 1'b0;
            if (r < 93)
                put_rate(site, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(SLOTS+1, 31),
                         $urandom());
            else
                send_spare();
        end
    endtask

    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (picks_pending != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    task automatic set_sites(input int v);
        settle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= SITE_COUNT_W'(v);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        scan_limit = (v > SITES) ? SITES : v;
    endtask

    // response side: random stalls, plus one long hold when asked
    initial
    begin
        int left;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            else if (left > 0)
            begin
                rsp_stall <= 1'b1;
                left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                left = idle_len();
            end
        end
    end

    initial
    begin
        bit counted;
        int done;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // known count for the first sites
        burst = 1'b1;
        for (int i = 0; i < FIRST_SITES; i++)
            put_count(i, 0);
        burst = 1'b0;
        set_sites(FIRST_SITES);

        // empty wheel
        ask_select('1, '1);
        put_rate(0, 1, 32'd5);
        put_rate(0, 2, 32'd0);
        put_rate(0, 3, 32'd7);
        put_count(0, 3);
        for (int s = 1; s <= SLOTS; s++)
            put_rate(2, s, '1);
        // saturating count
        put_count(2, 31);
        put_rate(SITES-1, 1, 32'd1);
        put_count(SITES-1, 1);
        // ignored slots and unused mode
        put_rate(3, 0, '1);
        put_rate(3, SLOTS+1, '1);
        put_rate(3, 31, '1);
        send_spare();
        // threshold equal to the fraction, strict compare
        ask_select(32'd4, 48'h0001_0000_0000);
        ask_select(32'd5, 48'h0001_0000_0000);
        ask_select('0, '0);
        ask_select('1, wheel_total());
        ask_select('1, '1);
        set_sites(0);
        ask_select($urandom(), '1);
        set_sites(1);
        ask_select('1, wheel_total());
        // slot carries over past empty sites
        set_sites(6);
        ask_select('1, '1);
        // scan limit above the table, stopped inside the covered sites
        set_sites(2047);
        ask_select($urandom(), wheel_total());

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       set_sites(SITES);
                1:       set_sites($urandom_range(1, 40));
                2:       set_sites($urandom_range(SITES+1, 2047));
                3:       set_sites(1);
                4:       set_sites($urandom_range(2, SITES));
                5:       set_sites(0);
                default: set_sites($urandom_range(1, 64));
            endcase
            burst = (ph == 2 || ph == 5);
            done  = 0;
            if (ph == 1)
            begin
                hold_req = 1'b1;
                random_select();
                random_select();
                done = 2;
            end
            while (done < PER_PHASE)
            begin
                random_item(counted);
                if (counted)
                    done++;
            end
        end
        burst = 1'b0;
        settle();

        if (fail_count == 0 && picks_pending == 0)
            $display("weighted_event_selector_tb OK");
        else
            $display("weighted_event_selector_tb NOT OK");
        $finish;
    end

endmodule
